FILE: sv/procedural_pattern_color_defines.svh
// Assertion helpers for the pattern color pipeline.
`ifndef PROCEDURAL_PATTERN_COLOR_DEFINES_SVH
`define PROCEDURAL_PATTERN_COLOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PPC_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("pattern color pipeline check failed");

// next-cycle implication, checked outside reset
`define PPC_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("pattern color pipeline check failed");

`endif

FILE: sv/ppc_pkg.sv
package ppc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = 32;
  localparam int CHAN_W          = 16;
  localparam int COLOR_W         = 3 * CHAN_W;
  localparam int SQUARE_W        = 2 * COORD_W;
  // integer part of x^2 + z^2 and its square root
  localparam int SQ_W            = SQUARE_W - 2 * COORD_FRAC_BITS;
  localparam int ROOT_W          = SQ_W / 2;
  localparam int REM_W           = ROOT_W + 2;
  localparam int STEPS_PER_STAGE = 4;
  localparam int ROOT_STAGES     = (ROOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIFF_W          = CHAN_W + 1;
  localparam int PROD_W          = DIFF_W + COORD_FRAC_BITS + 1;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND = 2'd2;

  typedef enum logic [1:0] {
    KIND_STRIPE   = 2'd0,
    KIND_GRADIENT = 2'd1,
    KIND_RING     = 2'd2,
    KIND_CHECKER  = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      on_plane;
  } point_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  // digit-by-digit square root state: operand bits left, remainder, root so far
  typedef struct packed {
    logic [SQ_W-1:0]   n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_t;

  // one result bit of the restoring square root
  function automatic root_t root_step(root_t cur);
    logic [REM_W:0] shifted;
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    root_t          nxt;
    shifted = {cur.rem[REM_W-2:0], cur.n[SQ_W-1 -: 2]};
    trial   = {1'b0, cur.root, 2'b01};
    diff    = shifted - trial;
    nxt.n   = {cur.n[SQ_W-3:0], 2'b00};
    if (shifted >= trial) begin
      nxt.rem  = diff[REM_W-1:0];
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = shifted[REM_W-1:0];
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

FILE: sv/procedural_pattern_color.sv
// Procedural pattern color: stripe, gradient, ring and checker textures.
// Input channel point_valid/point_ready carries one point word: x, y, z in
// signed Q16.16 and the on_plane flag. Output channel color_valid/color_ready
// carries one color word: red, green, blue in unsigned Q8.8.
// Config port: cfg_write with cfg_index 0 = pattern kind, 1 = first color,
// 2 = second color (red in bits 47:32); other indexes are ignored. Write only
// while the pipe is empty.
// A word passes the input, square, sum, square root and output stages in
// order to reach color. Throughput is one word per cycle while the receiver
// keeps color_ready high; the ring pattern's square root takes four result
// bits per stage and sets the pipe depth.
// Each stage holds its word until the next stage has room, so a stalled
// receiver backs the pipe up one stage at a time; point_ready stays high
// while any stage is empty. Nothing is lost or repeated.
// Reset empties the pipe and clears the kind (stripe) and both colors.
`include "procedural_pattern_color_defines.svh"

module procedural_pattern_color (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           point_valid,
  output logic                           point_ready,
  input  ppc_pkg::point_t                point,
  output logic                           color_valid,
  input  logic                           color_ready,
  output ppc_pkg::color_t                color,
  input  logic                           cfg_write,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppc_pkg::COLOR_W-1:0]    cfg_data
);
  import ppc_pkg::*;

  localparam int NST      = ROOT_STAGES + 4;
  localparam int ST_IN    = 0;
  localparam int ST_MUL   = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_ROOT0 = 3;
  localparam int ST_OUT   = NST - 1;

  kind_t  kind;
  color_t color_a;
  color_t color_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind    <= KIND_STRIPE;
      color_a <= '0;
      color_b <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KIND:   kind    <= kind_t'(cfg_data[1:0]);
        REG_FIRST:  color_a <= color_t'(cfg_data);
        REG_SECOND: color_b <= color_t'(cfg_data);
        default: ;
      endcase
    end
  end

  logic [2:0][CHAN_W-1:0] a_ch;
  logic [2:0][CHAN_W-1:0] b_ch;
  assign a_ch = {color_a.red, color_a.green, color_a.blue};
  assign b_ch = {color_b.red, color_b.green, color_b.blue};

  // stage handshake: a stage moves when it is empty or the next one moves
  logic [NST-1:0] v;
  logic [NST:0]   move;
  logic [NST-1:0] v_in;

  always_comb begin
    move[NST] = color_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      move[k] = !v[k] || move[k + 1];
    end
  end

  assign v_in        = {v[NST-2:0], point_valid};
  assign point_ready = move[ST_IN];
  assign color_valid = v[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (move[k]) v[k] <= v_in[k];
      end
    end
  end

  // stage 0: magnitudes, floor parity, fraction of x
  logic [COORD_W-1:0]         xr;
  logic [COORD_W-1:0]         zr;
  logic                       par_in;
  logic [COORD_W-1:0]         s0_mx;
  logic [COORD_W-1:0]         s0_mz;
  logic                       s0_par;
  logic [COORD_FRAC_BITS-1:0] s0_frac;

  assign xr = point.point_x;
  assign zr = point.point_z;

  always_comb begin
    case (kind)
      KIND_CHECKER: par_in = xr[COORD_FRAC_BITS] ^ zr[COORD_FRAC_BITS] ^
                             (!point.on_plane & point.point_y[COORD_FRAC_BITS]);
      default:      par_in = xr[COORD_FRAC_BITS];
    endcase
  end

  always_ff @(posedge clk) begin
    if (move[ST_IN]) begin
      s0_mx   <= xr[COORD_W-1] ? (~xr + COORD_W'(1)) : xr;
      s0_mz   <= zr[COORD_W-1] ? (~zr + COORD_W'(1)) : zr;
      s0_par  <= par_in;
      s0_frac <= xr[COORD_FRAC_BITS-1:0];
    end
  end

  // stage 1: squares and gradient products
  logic [SQUARE_W-1:0]                  sqx;
  logic [SQUARE_W-1:0]                  sqz;
  logic signed [PROD_W-1:0]             fa;
  logic [2:0][PROD_W-1:0]               prod;
  logic [SQUARE_W-1:0]                  s1_sqx;
  logic [SQUARE_W-1:0]                  s1_sqz;
  logic                                 s1_par;
  logic [2:0][PROD_W-1:0]               s1_prod;

  assign sqx = s0_mx * s0_mx;
  assign sqz = s0_mz * s0_mz;
  assign fa  = $signed(PROD_W'({1'b0, s0_frac}));

  always_comb begin
    logic signed [DIFF_W-1:0] dc;
    logic signed [PROD_W-1:0] da;
    for (int c = 0; c < 3; c++) begin
      dc      = $signed({1'b0, b_ch[c]}) - $signed({1'b0, a_ch[c]});
      da      = PROD_W'(dc);
      prod[c] = da * fa;
    end
  end

  always_ff @(posedge clk) begin
    if (move[ST_MUL]) begin
      s1_sqx  <= sqx;
      s1_sqz  <= sqz;
      s1_par  <= s0_par;
      s1_prod <= prod;
    end
  end

  // stage 2: integer part of the squared radius, gradient channels
  logic [SQUARE_W-1:0]    sum;
  logic [SQ_W-1:0]        s2_sq;
  logic                   s2_par;
  logic [2:0][CHAN_W-1:0] s2_grad;

  assign sum = s1_sqx + s1_sqz;

  always_ff @(posedge clk) begin
    if (move[ST_SUM]) begin
      s2_sq  <= sum[SQUARE_W-1 -: SQ_W];
      s2_par <= s1_par;
      for (int c = 0; c < 3; c++) begin
        // floor shift of the signed product keeps only bits above the fraction
        s2_grad[c] <= a_ch[c] + s1_prod[c][COORD_FRAC_BITS +: CHAN_W];
      end
    end
  end

  // square root stages, four result bits each
  root_t                  rs    [ROOT_STAGES];
  logic                   rpar  [ROOT_STAGES];
  logic [2:0][CHAN_W-1:0] rgrad [ROOT_STAGES];

  for (genvar r = 0; r < ROOT_STAGES; r++) begin : g_root
    root_t                  start;
    root_t                  walk;
    logic                   par_prev;
    logic [2:0][CHAN_W-1:0] grad_prev;

    if (r == 0) begin : g_first
      assign start     = '{n: s2_sq, rem: '0, root: '0};
      assign par_prev  = s2_par;
      assign grad_prev = s2_grad;
    end else begin : g_next
      assign start     = rs[r - 1];
      assign par_prev  = rpar[r - 1];
      assign grad_prev = rgrad[r - 1];
    end

    always_comb begin
      walk = start;
      for (int t = 0; t < STEPS_PER_STAGE; t++) begin
        if (r * STEPS_PER_STAGE + t < ROOT_W) walk = root_step(walk);
      end
    end

    always_ff @(posedge clk) begin
      if (move[ST_ROOT0 + r]) begin
        rs[r]    <= walk;
        rpar[r]  <= par_prev;
        rgrad[r] <= grad_prev;
      end
    end
  end

  // output stage
  logic  pick_b;
  root_t root_last;

  assign root_last = rs[ROOT_STAGES-1];

  always_comb begin
    case (kind)
      KIND_RING: pick_b = rs[ROOT_STAGES-1].root[0];
      default:   pick_b = rpar[ROOT_STAGES-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (move[ST_OUT]) begin
      if (kind == KIND_GRADIENT) begin
        color <= color_t'(rgrad[ROOT_STAGES-1]);
      end else begin
        color <= pick_b ? color_b : color_a;
      end
    end
  end

  `PPC_ASSERT_NOW(a_ready_with_room, color_ready || !(&v), point_ready)
  `PPC_ASSERT_NEXT(a_stall_keeps_word, v[ST_OUT-1] && !move[ST_OUT], v[ST_OUT-1])
  `PPC_ASSERT_NOW(a_root_rem_bound, v[ST_OUT-1], root_last.rem <= {1'b0, root_last.root, 1'b0})

endmodule

FILE: verif/procedural_pattern_color_tb.sv
`timescale 1ns / 100ps

module procedural_pattern_color_tb;
  import ppc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int RANDOM_WORDS = 550;
  localparam logic [COLOR_W-1:0] COLOR_A = 48'h1111_2222_3333;
  localparam logic [COLOR_W-1:0] COLOR_B = 48'hAAAA_BBBB_CCCC;
  localparam logic [COLOR_W-1:0] ALL_ONES = {COLOR_W{1'b1}};

  typedef struct {
    kind_t              kind;
    logic [COLOR_W-1:0] first;
    logic [COLOR_W-1:0] second;
    point_t             pt;
    bit                 known;
    color_t             want;
  } shade_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               point_valid = 1'b0;
  point_t             point = '0;
  logic               point_ready;
  logic               color_valid;
  logic               color_ready = 1'b0;
  color_t             color;
  logic               cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0] cfg_data = '0;

  // what the pattern registers hold right now
  kind_t              kind_now = KIND_STRIPE;
  logic [COLOR_W-1:0] first_now = '0;
  logic [COLOR_W-1:0] second_now = '0;

  // typed expectation travelling with the word on the point port
  bit                 point_known = 1'b0;
  color_t             point_want = '0;

  color_t             color_due[$];
  shade_row_t         shade_rows[$];
  int                 error_count = 0;
  bit                 sender_steady = 1'b0;
  bit                 sink_steady = 1'b0;
  bit                 hold_off_due = 1'b0;

  procedural_pattern_color dut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .color       (color),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("procedural_pattern_color_tb NOT OK");
    $finish;
  end

  function automatic logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                                   logic [COORD_FRAC_BITS-1:0] frac);
    longint av;
    longint bv;
    longint fr;
    longint q;
    av = a;
    bv = b;
    fr = frac;
    // arithmetic shift floors the signed product
    q = ((bv - av) * fr) >>> COORD_FRAC_BITS;
    return CHAN_W'(av + q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic color_t shade(point_t p);
    longint sx;
    longint sz;
    longint unsigned mx;
    longint unsigned mz;
    longint unsigned s;
    logic pick_b;
    color_t a;
    color_t b;
    color_t c;
    a = color_t'(first_now);
    b = color_t'(second_now);
    pick_b = 1'b0;
    case (kind_now)
      KIND_GRADIENT: begin
        c.red   = blend_chan(a.red, b.red, p.point_x[COORD_FRAC_BITS-1:0]);
        c.green = blend_chan(a.green, b.green, p.point_x[COORD_FRAC_BITS-1:0]);
        c.blue  = blend_chan(a.blue, b.blue, p.point_x[COORD_FRAC_BITS-1:0]);
        return c;
      end
      KIND_STRIPE: pick_b = p.point_x[COORD_FRAC_BITS];
      KIND_RING: begin
        sx = longint'($signed(p.point_x));
        sz = longint'($signed(p.point_z));
        mx = (sx < 0) ? -sx : sx;
        mz = (sz < 0) ? -sz : sz;
        s = (mx * mx + mz * mz) >> (2 * COORD_FRAC_BITS);
        pick_b = 1'(root_floor(s));
      end
      default: begin
        pick_b = p.point_x[COORD_FRAC_BITS] ^ p.point_z[COORD_FRAC_BITS];
        if (!p.on_plane) pick_b ^= p.point_y[COORD_FRAC_BITS];
      end
    endcase
    return pick_b ? b : a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int ip;
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: begin
        ip = int'($urandom_range(0, 15)) - 8;
        return {ip[15:0], 16'($urandom())};
      end
      3: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return 32'($signed($urandom()) >>> $urandom_range(4, 20));
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ALL_ONES;
      default: return COLOR_W'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic point_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic plane);
    point_t p;
    p.point_x  = x;
    p.point_y  = y;
    p.point_z  = z;
    p.on_plane = plane;
    return p;
  endfunction

  task automatic add_row(kind_t k, logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b, point_t p,
                         bit known, logic [COLOR_W-1:0] want);
    shade_row_t row;
    row.kind   = k;
    row.first  = a;
    row.second = b;
    row.pt     = p;
    row.known  = known;
    row.want   = color_t'(want);
    shade_rows.push_back(row);
  endtask

  task automatic wait_drained();
    point_valid <= 1'b0;
    do @(posedge clk); while (color_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(kind_t k, logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b,
                              bit all);
    wait_drained();
    if (all || k != kind_now) begin
      write_reg(REG_KIND, COLOR_W'(k));
      kind_now = k;
    end
    if (all || a != first_now) begin
      write_reg(REG_FIRST, a);
      first_now = a;
    end
    if (all || b != second_now) begin
      write_reg(REG_SECOND, b);
      second_now = b;
    end
    // unused index must leave every register alone
    if (all) write_reg(REG_UNUSED, COLOR_W'({$urandom(), $urandom()}));
    cfg_write <= 1'b0;
  endtask

  task automatic send_point(point_t p, bit known, color_t want);
    int g;
    g = sender_steady ? 0 : pick_gap();
    if (g > 0) begin
      point_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    point_valid <= 1'b1;
    point       <= p;
    point_known <= known;
    point_want  <= want;
    do @(posedge clk); while (!point_ready);
  endtask

  task automatic check_chan(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // retire results first, then log the word accepted at this edge
  always @(posedge clk) begin : check_colors
    color_t want;
    if (!rst) begin
      if (color_valid && color_ready) begin
        if (color_due.size() == 0) begin
          $display("%0t: unexpected color word, expected none got %h", $time, color);
          error_count++;
        end else begin
          want = color_due.pop_front();
          check_chan("red", want.red, color.red);
          check_chan("green", want.green, color.green);
          check_chan("blue", want.blue, color.blue);
        end
      end
      if (point_valid && point_ready) color_due.push_back(point_known ? point_want : shade(point));
    end
  end

  initial begin : color_sink
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = sink_steady ? 0 : pick_gap();
      end
      if (hold == 0) begin
        color_ready <= 1'b1;
      end else begin
        color_ready <= 1'b0;
        repeat (hold) @(posedge clk);
        color_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    shade_row_t row;
    point_t p;
    kind_t k;
    int sent;
    int phase;
    int n;

    // registers still at reset: everything reads back black
    add_row(KIND_STRIPE, '0, '0, make_point(32'h0001_0000, '0, '0, 1'b0), 1'b1, '0);
    add_row(KIND_STRIPE, COLOR_A, COLOR_B, make_point('0, '0, '0, 1'b0), 1'b1, COLOR_A);
    add_row(KIND_STRIPE, COLOR_A, COLOR_B,
            make_point(32'h0001_0000, '0, '0, 1'b0), 1'b1, COLOR_B);
    // tiny negative x floors to -1, odd
    add_row(KIND_STRIPE, COLOR_A, COLOR_B,
            make_point(32'hFFFF_FFFF, '0, '0, 1'b1), 1'b1, COLOR_B);
    add_row(KIND_STRIPE, COLOR_A, COLOR_B,
            make_point(32'h8000_0000, '0, '0, 1'b0), 1'b1, COLOR_A);
    add_row(KIND_STRIPE, COLOR_A, COLOR_B,
            make_point(32'h7FFF_FFFF, '0, '0, 1'b0), 1'b1, COLOR_B);
    add_row(KIND_GRADIENT, '0, ALL_ONES, make_point('0, '0, '0, 1'b0), 1'b1, '0);
    add_row(KIND_GRADIENT, '0, ALL_ONES,
            make_point(32'h0000_FFFF, '0, '0, 1'b0), 1'b0, '0);
    // falling blend, negative difference
    add_row(KIND_GRADIENT, ALL_ONES, '0,
            make_point(32'h0000_8000, '0, '0, 1'b0), 1'b0, '0);
    add_row(KIND_GRADIENT, ALL_ONES, '0,
            make_point(32'hFFFF_0001, '0, '0, 1'b0), 1'b0, '0);
    add_row(KIND_GRADIENT, COLOR_A, COLOR_B,
            make_point(32'h1234_5678, '0, '0, 1'b0), 1'b0, '0);
    add_row(KIND_RING, COLOR_A, COLOR_B, make_point('0, '0, '0, 1'b0), 1'b1, COLOR_A);
    add_row(KIND_RING, COLOR_A, COLOR_B,
            make_point(32'h0001_0000, '0, '0, 1'b0), 1'b1, COLOR_B);
    add_row(KIND_RING, COLOR_A, COLOR_B,
            make_point(32'h8000_0000, '0, 32'h8000_0000, 1'b0), 1'b0, '0);
    add_row(KIND_RING, COLOR_A, COLOR_B,
            make_point(32'h7FFF_FFFF, '0, 32'h8000_0000, 1'b1), 1'b0, '0);
    add_row(KIND_RING, COLOR_A, COLOR_B,
            make_point(32'hFFFE_0000, '0, 32'h0001_8000, 1'b0), 1'b0, '0);
    add_row(KIND_CHECKER, COLOR_A, COLOR_B, make_point('0, '0, '0, 1'b0), 1'b1, COLOR_A);
    add_row(KIND_CHECKER, COLOR_A, COLOR_B,
            make_point('0, 32'h0001_0000, '0, 1'b0), 1'b1, COLOR_B);
    // same point on a plane ignores y
    add_row(KIND_CHECKER, COLOR_A, COLOR_B,
            make_point('0, 32'h0001_0000, '0, 1'b1), 1'b1, COLOR_A);
    add_row(KIND_CHECKER, COLOR_A, COLOR_B,
            make_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0), 1'b0, '0);
    add_row(KIND_CHECKER, COLOR_A, COLOR_B,
            make_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (shade_rows[i]) begin
      row = shade_rows[i];
      if (row.kind != kind_now || row.first != first_now || row.second != second_now)
        apply_config(row.kind, row.first, row.second, 1'b0);
      send_point(row.pt, row.known, row.want);
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      k = (phase < 4) ? kind_t'(phase) : kind_t'($urandom_range(0, 3));
      apply_config(k, rand_color(), rand_color(), 1'b1);
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        // sink backs off while words keep coming, pipe must fill and stall
        sender_steady = 1'b1;
        sink_steady = 1'b0;
        hold_off_due = 1'b1;
      end
      n = $urandom_range(20, 70);
      if (n > RANDOM_WORDS - sent) n = RANDOM_WORDS - sent;
      repeat (n) begin
        p.point_x  = rand_coord();
        p.point_y  = rand_coord();
        p.point_z  = rand_coord();
        p.on_plane = 1'($urandom_range(0, 1));
        send_point(p, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    wait_drained();
    if (error_count == 0) begin
      $display("procedural_pattern_color_tb OK");
    end else begin
      $display("procedural_pattern_color_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/ppc_pkg.sv
sv/procedural_pattern_color.sv
verif/procedural_pattern_color_tb.sv
